// ===== hdl/dpc_pkg.sv =====
package dpc_pkg;

    // Field widths of the two input channels and the dew point output.
    localparam int T_W  = 15;
    localparam int H_W  = 14;
    localparam int DP_W = 15;

    // Fixed-point settings.
    localparam int FRAC_BITS_DEF = 16;
    localparam int E_W           = 4;
    localparam int MANT_BITS     = 30;
    localparam int M_W           = MANT_BITS + 1;
    localparam int LOG10_2_Q30   = 323228497;
    localparam int LOG_C_W       = 29;

    // Magnus constants in hundredths.
    localparam int MAGNUS_A_CENTI = 1762;
    localparam int MAGNUS_B_CENTI = 24312;
    localparam int DEN_SCALE      = 100;
    localparam int DEN2_W         = 22;
    localparam int PROD2_W        = 26;
    localparam int T1_DIV         = 4343;
    localparam int T1_SCALE       = 10000;
    localparam int T1_QUO_INT     = T1_SCALE / T1_DIV;
    localparam int T1_REM_SCALE   = T1_SCALE - T1_QUO_INT * T1_DIV;
    localparam int DP_SCALE       = 2431200;
    localparam int DP_SCALE_W     = 23;

    // Output saturation limits.
    localparam int DP_MAX     = 16383;
    localparam int DP_NEG_MAG = 16384;

    typedef struct packed {
        logic signed [T_W-1:0] temp_centi;
        logic [H_W-1:0]        humidity_centi;
    } t_dpc_in;

    typedef struct packed {
        logic signed [DP_W-1:0] dew_point_centi;
        logic                   invalid;
    } t_dpc_out;

endpackage

// ===== hdl/dpc_log_cell.sv =====
// One squaring step of the base-2 logarithm: squares the mantissa and
// renormalizes it, setting one result bit when the square reaches two.
module dpc_log_cell import dpc_pkg::*; #(
    parameter int RW  = 20,
    parameter int BIT = 0,
    parameter int SW  = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [M_W-1:0] i_m,
    input  logic [RW-1:0]  i_r,
    input  logic [SW-1:0]  i_side,
    output logic           o_valid,
    output logic [M_W-1:0] o_m,
    output logic [RW-1:0]  o_r,
    output logic [SW-1:0]  o_side
);

    logic [2*M_W-1:0] w_sq;
    logic [M_W:0]     w_m2;
    logic [M_W-1:0]   n_m;
    logic [RW-1:0]    n_r;
    logic             r_valid;
    logic [M_W-1:0]   r_m;
    logic [RW-1:0]    r_r;
    logic [SW-1:0]    r_side;

    always_comb begin
        w_sq = (2*M_W)'(i_m) * (2*M_W)'(i_m);
        w_m2 = w_sq[MANT_BITS +: M_W+1];
        if (w_m2[M_W]) begin
            n_m = w_m2[M_W:1];
            n_r = i_r | (RW'(1) << BIT);
        end else begin
            n_m = w_m2[M_W-1:0];
            n_r = i_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m    <= n_m;
            r_r    <= n_r;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_m     = r_m;
    assign o_r     = r_r;
    assign o_side  = r_side;

endmodule

// ===== hdl/dpc_div_cell.sv =====
// One restoring division step: brings down the next numerator bit and
// shifts one quotient bit into the low end of the numerator register.
module dpc_div_cell #(
    parameter int NW = 16,
    parameter int DW = 8,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [NW-1:0] i_aq,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_rem,
    output logic [NW-1:0] o_aq,
    output logic [DW-1:0] o_den,
    output logic [SW-1:0] o_side
);

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [DW-1:0] n_rem;
    logic [NW-1:0] n_aq;
    logic          r_valid;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_aq;
    logic [DW-1:0] r_den;
    logic [SW-1:0] r_side;

    always_comb begin
        w_trial = {i_rem, i_aq[NW-1]};
        w_diff  = w_trial - {1'b0, i_den};
        w_ge    = (w_trial >= {1'b0, i_den});
        n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        n_aq    = {i_aq[NW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_aq   <= n_aq;
            r_den  <= i_den;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_aq    = r_aq;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

// ===== hdl/dpc_divider.sv =====
// Pipelined unsigned divider: a row of NW restoring cells, one quotient
// bit per cell, with side data traveling alongside.
module dpc_divider #(
    parameter int NW = 16,
    parameter int DW = 8,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          w_valid [0:NW];
    logic [DW-1:0] w_rem   [0:NW];
    logic [NW-1:0] w_aq    [0:NW];
    logic [DW-1:0] w_den   [0:NW];
    logic [SW-1:0] w_side  [0:NW];

    assign w_valid[0] = i_valid;
    assign w_rem[0]   = '0;
    assign w_aq[0]    = i_num;
    assign w_den[0]   = i_den;
    assign w_side[0]  = i_side;

    for (genvar k = 0; k < NW; k++) begin : g_cell
        dpc_div_cell #(
            .NW (NW),
            .DW (DW),
            .SW (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_valid[k]),
            .i_rem   (w_rem[k]),
            .i_aq    (w_aq[k]),
            .i_den   (w_den[k]),
            .i_side  (w_side[k]),
            .o_valid (w_valid[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_aq    (w_aq[k+1]),
            .o_den   (w_den[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    assign o_valid = w_valid[NW];
    assign o_quo   = w_aq[NW];
    assign o_side  = w_side[NW];

endmodule

// ===== hdl/dew_point_calculator.sv =====
// Magnus dew point calculator. Each input beat carries an air temperature in
// hundredths of a degree Celsius and a relative humidity in hundredths of a
// percent; each output beat carries the dew point in hundredths of a degree,
// rounded to nearest, and an invalid flag that is set (with a zero result)
// when the humidity is zero. The block is a fully pipelined row of cells and
// takes one beat in every clock cycle. Its latency is set by the FRAC_BITS
// squaring cells of the logarithm, the FRAC_BITS+26 cells of the divider that
// forms the second Magnus term, the FRAC_BITS+30 cells of the final divider,
// and eight registered arithmetic stages. The first Magnus term divides by a
// constant, so it is formed by a reciprocal multiplication whose operands
// ride alongside the second term's divider. The whole pipeline advances
// together: it stalls only while a finished result sits in the output
// register and the receiver holds ready low. No state is kept between
// samples.
module dew_point_calculator import dpc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dpc_in  i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_dpc_out o_data
);

    localparam int RW   = FRAC_BITS + E_W;
    localparam int L10W = FRAC_BITS + 3;
    localparam int DNW  = FRAC_BITS + 26;
    localparam int QW   = FRAC_BITS + 7;
    localparam int GW   = FRAC_BITS + 8;
    localparam int N3W  = GW + DP_SCALE_W;
    localparam int D3SW = FRAC_BITS + 16;
    localparam int D3W  = FRAC_BITS + 14;
    localparam int NW3  = FRAC_BITS + 30;
    localparam int LSW  = T_W + 1;
    localparam int M1W  = FRAC_BITS + 13;
    localparam int RCW  = FRAC_BITS + 14;
    localparam int T1_SHIFT = FRAC_BITS + 26;
    localparam int Q1LW = M1W + RCW - T1_SHIFT;
    localparam int T2SW = M1W + L10W + 3;
    localparam longint T1_RECIP =
        ((longint'(1) <<< T1_SHIFT) + longint'(T1_DIV - 1)) / longint'(T1_DIV);

    // The pipeline moves whenever the output register is free or emptying.
    logic r_out_valid;
    logic w_en;
    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en;

    // Normalization: find the leading one of the humidity and place the
    // humidity as a Q30 mantissa in [1,2). The integer part of the log is e.
    logic [E_W-1:0] w_e;
    logic [M_W-1:0] w_m0;
    logic           r_a_valid;
    logic [M_W-1:0] r_a_m;
    logic [RW-1:0]  r_a_r;
    logic [LSW-1:0] r_a_side;

    always_comb begin
        w_e = '0;
        for (int k = 1; k < H_W; k++) begin
            if (i_data.humidity_centi[k]) begin
                w_e = E_W'(k);
            end
        end
        w_m0 = M_W'(i_data.humidity_centi) << (MANT_BITS - int'(w_e));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_m    <= w_m0;
            r_a_r    <= RW'(w_e) << FRAC_BITS;
            r_a_side <= {i_data.temp_centi, (i_data.humidity_centi == '0)};
        end
    end

    // Fraction bits of log2: one squaring cell per bit, most significant
    // bit first. The temperature and invalid flag ride along as side data.
    logic           w_lg_valid [0:FRAC_BITS];
    logic [M_W-1:0] w_lg_m     [0:FRAC_BITS];
    logic [RW-1:0]  w_lg_r     [0:FRAC_BITS];
    logic [LSW-1:0] w_lg_side  [0:FRAC_BITS];

    assign w_lg_valid[0] = r_a_valid;
    assign w_lg_m[0]     = r_a_m;
    assign w_lg_r[0]     = r_a_r;
    assign w_lg_side[0]  = r_a_side;

    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_log
        dpc_log_cell #(
            .RW  (RW),
            .BIT (FRAC_BITS - 1 - k),
            .SW  (LSW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_lg_valid[k]),
            .i_m     (w_lg_m[k]),
            .i_r     (w_lg_r[k]),
            .i_side  (w_lg_side[k]),
            .o_valid (w_lg_valid[k+1]),
            .o_m     (w_lg_m[k+1]),
            .o_r     (w_lg_r[k+1]),
            .o_side  (w_lg_side[k+1])
        );
    end

    // Stage L: log10 from log2, and the temperature products for the
    // second Magnus term (magnitude times 17.62 and the divisor).
    logic [RW+LOG_C_W-1:0]  w_l_prod;
    logic signed [T_W-1:0]  w_l_t;
    logic [T_W-1:0]         w_l_tabs;
    logic signed [T_W+1:0]  w_l_tsum;
    logic                   r_l_valid;
    logic [L10W-1:0]        r_l_l10;
    logic [PROD2_W-1:0]     r_l_prod2;
    logic                   r_l_negt;
    logic [DEN2_W-1:0]      r_l_den2;
    logic                   r_l_inv;

    always_comb begin
        w_l_prod = (RW+LOG_C_W)'(w_lg_r[FRAC_BITS]) * (RW+LOG_C_W)'(LOG10_2_Q30)
                 + ((RW+LOG_C_W)'(1) << (MANT_BITS - 1));
        w_l_t    = $signed(w_lg_side[FRAC_BITS][LSW-1:1]);
        w_l_tabs = w_l_t[T_W-1] ? T_W'(~w_l_t + 1'b1) : T_W'(w_l_t);
        w_l_tsum = (T_W+2)'(MAGNUS_B_CENTI) + (T_W+2)'(w_l_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_valid <= 1'b0;
        end else if (w_en) begin
            r_l_valid <= w_lg_valid[FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l_l10   <= w_l_prod[MANT_BITS +: L10W];
            r_l_prod2 <= PROD2_W'(w_l_tabs) * PROD2_W'(MAGNUS_A_CENTI);
            r_l_negt  <= w_l_t[T_W-1];
            r_l_den2  <= DEN2_W'(w_l_tsum[T_W:0]) * DEN2_W'(DEN_SCALE);
            r_l_inv   <= w_lg_side[FRAC_BITS][0];
        end
    end

    // Stage P: rounded dividends for both Magnus terms. The first term,
    // (log10(H) - 4) * 10000 / 4343, is split into twice the magnitude plus
    // (1314 * magnitude + 2171) / 4343; this stage forms that second
    // dividend. The second term is 1762*T*2^F / (100*(24312+T)).
    logic [L10W-1:0] w_p_four;
    logic            w_p_neg1;
    logic [L10W-1:0] w_p_abs;
    logic            r_p_valid;
    logic [M1W-1:0]  r_p_num1;
    logic [L10W-1:0] r_p_abs1;
    logic            r_p_neg1;
    logic [DNW-1:0]  r_p_num2;
    logic [DEN2_W-1:0] r_p_den2;
    logic            r_p_neg2;
    logic            r_p_inv;

    always_comb begin
        w_p_four = L10W'(4) << FRAC_BITS;
        w_p_neg1 = r_l_l10 < w_p_four;
        w_p_abs  = w_p_neg1 ? (w_p_four - r_l_l10) : (r_l_l10 - w_p_four);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid <= r_l_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_num1 <= M1W'(w_p_abs) * M1W'(T1_REM_SCALE) + M1W'(T1_DIV / 2);
            r_p_abs1 <= w_p_abs;
            r_p_neg1 <= w_p_neg1;
            r_p_num2 <= (DNW'(r_l_prod2) << FRAC_BITS) + DNW'(r_l_den2 >> 1);
            r_p_den2 <= r_l_den2;
            r_p_neg2 <= r_l_negt;
            r_p_inv  <= r_l_inv;
        end
    end

    // The second Magnus term divides by a temperature-dependent divisor in
    // a row of cells; the first term's operands travel alongside it.
    logic            w_d2_valid;
    logic [DNW-1:0]  w_q2;
    logic [T2SW-1:0] w_s2;

    dpc_divider #(
        .NW (DNW),
        .DW (DEN2_W),
        .SW (T2SW)
    ) u_div_term2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p_valid),
        .i_num   (r_p_num2),
        .i_den   (r_p_den2),
        .i_side  ({r_p_num1, r_p_abs1, r_p_neg1, r_p_neg2, r_p_inv}),
        .o_valid (w_d2_valid),
        .o_quo   (w_q2),
        .o_side  (w_s2)
    );

    // Stage T: the first Magnus term. The reciprocal of 4343 is scaled so
    // that the truncated product equals the exact quotient over the whole
    // dividend range.
    logic [M1W-1:0]     w_t_m;
    logic [L10W-1:0]    w_t_d;
    logic               w_t_neg1;
    logic               w_t_neg2;
    logic               w_t_inv;
    logic [M1W+RCW-1:0] w_t_prod;
    logic               r_t_valid;
    logic [QW-1:0]      r_t_q1;
    logic               r_t_neg1;
    logic [QW-1:0]      r_t_q2;
    logic               r_t_neg2;
    logic               r_t_inv;

    always_comb begin
        {w_t_m, w_t_d, w_t_neg1, w_t_neg2, w_t_inv} = w_s2;
        w_t_prod = (M1W+RCW)'(w_t_m) * (M1W+RCW)'(T1_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
        end else if (w_en) begin
            r_t_valid <= w_d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t_q1   <= QW'(w_t_d) * QW'(T1_QUO_INT) + QW'(w_t_prod[T1_SHIFT +: Q1LW]);
            r_t_neg1 <= w_t_neg1;
            r_t_q2   <= w_q2[QW-1:0];
            r_t_neg2 <= w_t_neg2;
            r_t_inv  <= w_t_inv;
        end
    end

    // Stage G: apply the signs and add the terms to form g.
    logic signed [GW-1:0] w_g_t1;
    logic signed [GW-1:0] w_g_t2;
    logic                 r_g_valid;
    logic signed [GW-1:0] r_g_g;
    logic                 r_g_inv;

    always_comb begin
        w_g_t1 = $signed(GW'(r_t_q1));
        w_g_t2 = $signed(GW'(r_t_q2));
        if (r_t_neg1) begin
            w_g_t1 = -w_g_t1;
        end
        if (r_t_neg2) begin
            w_g_t2 = -w_g_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (w_en) begin
            r_g_valid <= r_t_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_g   <= w_g_t1 + w_g_t2;
            r_g_inv <= r_t_inv;
        end
    end

    // Stage N: dividend 243.12*g and divisor 17.62 - g for the dew point.
    logic signed [D3SW-1:0] w_n_den;
    logic                   r_n_valid;
    logic signed [N3W-1:0]  r_n_num;
    logic [D3W-1:0]         r_n_den;
    logic                   r_n_inv;

    always_comb begin
        w_n_den = (D3SW'(MAGNUS_A_CENTI) <<< FRAC_BITS)
                - D3SW'(r_g_g) * D3SW'(DEN_SCALE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
        end else if (w_en) begin
            r_n_valid <= r_g_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n_num <= N3W'(r_g_g) * N3W'(DP_SCALE);
            r_n_den <= D3W'(w_n_den);
            r_n_inv <= r_g_inv;
        end
    end

    // Stage Q: magnitude of the dividend plus half the divisor, which
    // turns the truncating divider into round half away from zero.
    logic [N3W-1:0] w_q_mag;
    logic           r_q_valid;
    logic [NW3-1:0] r_q_num;
    logic [D3W-1:0] r_q_den;
    logic           r_q_neg;
    logic           r_q_inv;

    assign w_q_mag = r_n_num[N3W-1] ? N3W'(-r_n_num) : N3W'(r_n_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (w_en) begin
            r_q_valid <= r_n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q_num <= NW3'(w_q_mag) + NW3'(r_n_den >> 1);
            r_q_den <= r_n_den;
            r_q_neg <= r_n_num[N3W-1];
            r_q_inv <= r_n_inv;
        end
    end

    logic           w_d3_valid;
    logic [NW3-1:0] w_q3;
    logic [1:0]     w_s3;

    dpc_divider #(
        .NW (NW3),
        .DW (D3W),
        .SW (2)
    ) u_div_dew (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_q_valid),
        .i_num   (r_q_num),
        .i_den   (r_q_den),
        .i_side  ({r_q_neg, r_q_inv}),
        .o_valid (w_d3_valid),
        .o_quo   (w_q3),
        .o_side  (w_s3)
    );

    // Output register: sign, saturation to the field, and the zero result
    // for an invalid sample. It holds its beat while the receiver stalls.
    t_dpc_out n_out;
    t_dpc_out r_out;

    always_comb begin
        n_out.invalid = w_s3[0];
        if (w_s3[0]) begin
            n_out.dew_point_centi = '0;
        end else if (w_s3[1]) begin
            if (w_q3 > NW3'(DP_NEG_MAG)) begin
                n_out.dew_point_centi = DP_W'(-DP_NEG_MAG);
            end else begin
                n_out.dew_point_centi = -$signed(DP_W'(w_q3));
            end
        end else begin
            if (w_q3 > NW3'(DP_MAX)) begin
                n_out.dew_point_centi = DP_W'(DP_MAX);
            end else begin
                n_out.dew_point_centi = $signed(DP_W'(w_q3));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_d3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== hdl/dpc_checker.sv =====
// Port-level checks for the dew point calculator.
module dpc_checker import dpc_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_valid,
    input logic     o_ready,
    input t_dpc_in  i_data,
    input logic     o_valid,
    input logic     i_ready,
    input t_dpc_out o_data
);

    // A result beat stays offered until the receiver takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output beat dropped before it was taken");

    // An invalid sample always reports a zero dew point.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.invalid |-> o_data.dew_point_centi == '0)
        else $error("invalid beat carries a nonzero dew point");

    // With no result waiting, the pipeline must be free to take a beat.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while the output register is empty");

endmodule

bind dew_point_calculator dpc_checker u_dpc_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Checks the Magnus dew point pipeline against a fixed-point predictor that
// mirrors its arithmetic. Input beats are queued up front and sent by a
// clocked driver. A clocked monitor compares each output beat with the oldest
// queued expectation. Traffic runs in several phases of sender and receiver
// idling, and one of them holds the receiver off long enough to fill the
// pipeline.
module testbench;
    import dpc_pkg::*;

    localparam int LATENCY   = 3 * FRAC_BITS_DEF + 64;
    localparam int CYCLE_CAP = 400000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    t_dpc_in  in_beat;
    logic     out_valid;
    logic     out_ready;
    t_dpc_out out_beat;

    // Pending input beats, and the dew points expected back, oldest first.
    t_dpc_in  send_q[$];
    t_dpc_out dew_q[$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off_cycles;
    int  mismatches;
    int  cycles;

    dew_point_calculator uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_beat),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_beat)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Division rounded half away from zero, for a positive divisor.
    function automatic longint div_round_away(longint num, longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    // log2 of the humidity in Q.FRAC_BITS, found by repeated squaring of a
    // Q30 mantissa. Each squaring is truncated back to Q30.
    function automatic longint humidity_log2(int unsigned h);
        int unsigned  e;
        logic [63:0]  m;
        logic [63:0]  r;
        e = 0;
        while (e < 31 && (h >> (e + 1)) != 0)
            e++;
        m = 64'(h) << (MANT_BITS - e);
        r = 64'(e) << FRAC_BITS_DEF;
        for (int i = FRAC_BITS_DEF - 1; i >= 0; i--) begin
            m = (m * m) >> MANT_BITS;
            if (m >= (64'd2 << MANT_BITS)) begin
                m = m >> 1;
                r[i] = 1'b1;
            end
        end
        return longint'(r);
    endfunction

    function automatic t_dpc_out predict_dew_point(t_dpc_in s);
        t_dpc_out    res;
        longint      one;
        longint      t;
        longint      l2;
        longint      l10;
        longint      term1;
        longint      term2;
        longint      g;
        longint      dp;
        logic [63:0] prod;
        one = longint'(1) << FRAC_BITS_DEF;
        t   = longint'(s.temp_centi);
        res = '0;
        if (s.humidity_centi == 0) begin
            res.invalid = 1'b1;
            return res;
        end
        l2    = humidity_log2(int'(s.humidity_centi));
        prod  = 64'(l2) * 64'(LOG10_2_Q30) + (64'd1 << (MANT_BITS - 1));
        l10   = longint'(prod >> MANT_BITS);
        term1 = div_round_away((l10 - 4 * one) * T1_SCALE, T1_DIV);
        term2 = div_round_away(MAGNUS_A_CENTI * t * one, DEN_SCALE * (MAGNUS_B_CENTI + t));
        g     = term1 + term2;
        dp    = div_round_away(DP_SCALE * g, MAGNUS_A_CENTI * one - DEN_SCALE * g);
        if (dp < -DP_NEG_MAG)
            dp = -DP_NEG_MAG;
        if (dp > DP_MAX)
            dp = DP_MAX;
        res.dew_point_centi = DP_W'(dp);
        return res;
    endfunction

    function automatic void queue_sample(int t, int h);
        t_dpc_in s;
        s.temp_centi     = T_W'(t);
        s.humidity_centi = H_W'(h);
        send_q.push_back(s);
    endfunction

    // Random sample: mostly within the sensor ranges, sometimes any pattern.
    function automatic void queue_random_sample();
        int t;
        int h;
        if ($urandom_range(0, 9) < 8) begin
            t = int'($urandom_range(0, 12500)) - 4000;
            h = $urandom_range(0, 10000);
        end else begin
            t = $urandom;
            h = $urandom;
        end
        queue_sample(t, h);
    endfunction

    // Driver: valid holds with its payload until the beat is taken.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                dew_q.push_back(predict_dew_point(in_beat));
                void'(send_q.pop_front());
            end
            // The head of the queue is the beat on the wire while valid is high.
            if (in_valid && !in_ready) begin
                in_valid <= 1'b1;
            end else if (in_valid && in_ready) begin
                if (send_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_beat  <= send_q[0];
                end else begin
                    in_valid <= 1'b0;
                end
            end else if (send_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_beat  <= send_q[0];
            end
        end
    end

    // Monitor: every output beat is checked against the oldest expectation.
    always @(posedge clk) begin
        t_dpc_out want;
        if (rst_n && out_valid && out_ready) begin
            if (dew_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output beat: dp=%0d invalid=%0b",
                             out_beat.dew_point_centi, out_beat.invalid);
            end else begin
                want = dew_q.pop_front();
                if (want.dew_point_centi !== out_beat.dew_point_centi ||
                    want.invalid !== out_beat.invalid) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"dew point mismatch: expected dp=%0d invalid=%0b, ",
                                  "got dp=%0d invalid=%0b"},
                                 want.dew_point_centi, want.invalid,
                                 out_beat.dew_point_centi, out_beat.invalid);
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready       <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("[dew_point_calculator] ERROR");
            $finish;
        end
    end

    initial begin
        int tail;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_beat         = '0;
        out_ready       = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        mismatches      = 0;
        cycles          = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed samples: range corners, zero humidity, raw field extremes.
        queue_sample(-4000, 10000);
        queue_sample(-4000, 1);
        queue_sample(8500, 10000);
        queue_sample(8500, 1);
        queue_sample(0, 5000);
        queue_sample(2000, 0);
        queue_sample(-4000, 0);
        queue_sample(0, 10000);
        queue_sample(2500, 6000);
        queue_sample(-1, 9999);
        queue_sample(1, 2);
        queue_sample('h3fff, 'h3fff);
        queue_sample('h4000, 'h3fff);
        queue_sample('h7fff, 'h2aaa);
        queue_sample('h2aaa, 'h1555);
        queue_sample('h5555, 'h0001);
        queue_sample('h4000, 'h0000);
        queue_sample('h3fff, 'h2000);

        // Phases: no idling, idle sender, stalling receiver, both.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1 || phase == 3) ? 73 : 0;
            recv_stall_pct = (phase == 2) ? 73 : (phase == 3) ? 11 : 0;
            if (phase == 3)
                send_idle_pct = 11;
            for (int n = 0; n < 320; n++)
                queue_random_sample();
            // Fill the pipeline against a receiver that holds off.
            if (phase == 0)
                hold_off_cycles = 3 * LATENCY;
            while (send_q.size() > 0)
                @(posedge clk);
        end

        while (dew_q.size() > 0)
            @(posedge clk);
        tail = 0;
        while (tail < 2 * LATENCY) begin
            @(posedge clk);
            tail++;
        end

        if (mismatches == 0 && dew_q.size() == 0) begin
            $display("[dew_point_calculator] OK");
        end else begin
            $display("[dew_point_calculator] ERROR");
        end
        $finish;
    end
endmodule
